/* rtl/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on the clock, disabled in reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

/* rtl/mbet_pkg.sv */
// shared types, constants and helpers for the escape-time pixel engine
// no dependencies
package mbet_pkg;
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 28;
    localparam int POINT_W    = 32;
    localparam int Z_W        = 34;
    localparam int CNT_W      = 16;
    localparam int SIZE_W     = 13;
    localparam int PROD_W     = 2 * Z_W;
    localparam int CAP_W      = 62;

    // configuration register indexes
    localparam logic [2:0] REG_SCALE_X  = 3'd0;
    localparam logic [2:0] REG_SCALE_Y  = 3'd1;
    localparam logic [2:0] REG_OFFSET_X = 3'd2;
    localparam logic [2:0] REG_OFFSET_Y = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;
    localparam logic [2:0] REG_HEIGHT   = 3'd5;
    localparam logic [2:0] REG_LIMIT    = 3'd6;
    localparam logic [2:0] REG_SSMODE   = 3'd7;

    // one sample point handed from front to back
    typedef struct packed {
        logic signed [POINT_W-1:0] cr;
        logic signed [POINT_W-1:0] ci;
        logic [1:0]                idx;
        logic                      last;
    } t_point;

    typedef enum logic [1:0] {
        T_FE_IDLE,
        T_FE_MAP,
        T_FE_EMIT
    } t_fe_state;

    typedef enum logic [2:0] {
        T_BE_IDLE,
        T_BE_MUL,
        T_BE_UPD,
        T_BE_CHK,
        T_BE_OUT
    } t_be_state;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [POINT_W-1:0] sat_point(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sh0000_7FFF_FFFF;
        lo = -hi - 48'sd1;
        if (v > hi) return POINT_W'(hi);
        else if (v < lo) return POINT_W'(lo);
        else return v[POINT_W-1:0];
    endfunction

    // saturate to the z width
    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [CAP_W+1:0] v);
        logic signed [CAP_W+1:0] hi;
        logic signed [CAP_W+1:0] lo;
        hi = (CAP_W+2)'((64'sd1 <<< (Z_W-1)) - 64'sd1);
        lo = -hi - 1;
        if (v > hi) return Z_W'(hi);
        else if (v < lo) return Z_W'(lo);
        else return v[Z_W-1:0];
    endfunction

    // floor shift of a full product, magnitude capped at 2^60
    function automatic logic signed [CAP_W-1:0] scale_prod(
        input logic signed [PROD_W-1:0] p, input logic dbl);
        logic signed [PROD_W-1:0] s;
        logic signed [PROD_W-1:0] cap;
        cap = PROD_W'(64'sd1 <<< 60);
        s = dbl ? (p >>> (FRAC_BITS-1)) : (p >>> FRAC_BITS);
        if (s > cap) s = cap;
        else if (s < -cap) s = -cap;
        return s[CAP_W-1:0];
    endfunction
endpackage

/* rtl/mbet_front.sv */
// front end: maps pixel coordinates to sample points, one or four per pixel
// depends on mbet_pkg
module mbet_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [mbet_pkg::COORD_BITS-1:0]   i_px,
    input  logic [mbet_pkg::COORD_BITS-1:0]   i_py,
    input  logic signed [mbet_pkg::POINT_W-1:0] i_scale_x,
    input  logic signed [mbet_pkg::POINT_W-1:0] i_scale_y,
    input  logic signed [mbet_pkg::POINT_W-1:0] i_offset_x,
    input  logic signed [mbet_pkg::POINT_W-1:0] i_offset_y,
    input  logic [mbet_pkg::SIZE_W-1:0]       i_width,
    input  logic [mbet_pkg::SIZE_W-1:0]       i_height,
    input  logic                              i_ssmode,
    output logic                              o_pt_valid,
    input  logic                              i_pt_ready,
    output mbet_pkg::t_point                  o_pt
);
    mbet_pkg::t_fe_state r_state, n_state;
    logic signed [mbet_pkg::SIZE_W:0]    r_dx, r_dy;
    logic signed [mbet_pkg::POINT_W-1:0] r_cr, r_ci;
    logic [1:0]                          r_k;
    logic signed [47:0] w_mx, w_my;
    logic signed [mbet_pkg::POINT_W-1:0] w_qx, w_qy;
    logic signed [47:0] w_sr, w_si;

    // centered coordinates times scale, plus offset
    assign w_mx = 48'(r_dx) * 48'(i_scale_x) + 48'(i_offset_x);
    assign w_my = 48'(r_dy) * 48'(i_scale_y) + 48'(i_offset_y);
    assign w_qx = i_scale_x >>> 2;
    assign w_qy = i_scale_y >>> 2;
    assign w_sr = r_k[1] ? 48'(r_cr) + 48'(w_qx) : 48'(r_cr) - 48'(w_qx);
    assign w_si = r_k[0] ? 48'(r_ci) + 48'(w_qy) : 48'(r_ci) - 48'(w_qy);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mbet_pkg::T_FE_IDLE: if (i_valid) n_state = mbet_pkg::T_FE_MAP;
            mbet_pkg::T_FE_MAP:  n_state = mbet_pkg::T_FE_EMIT;
            mbet_pkg::T_FE_EMIT: begin
                if (i_pt_ready && (!i_ssmode || r_k == 2'd3)) n_state = mbet_pkg::T_FE_IDLE;
            end
            default: n_state = mbet_pkg::T_FE_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready    = (r_state == mbet_pkg::T_FE_IDLE);
        o_pt_valid = (r_state == mbet_pkg::T_FE_EMIT);
        if (i_ssmode) begin
            o_pt.cr   = mbet_pkg::sat_point(w_sr);
            o_pt.ci   = mbet_pkg::sat_point(w_si);
            o_pt.idx  = r_k;
            o_pt.last = (r_k == 2'd3);
        end else begin
            o_pt.cr   = r_cr;
            o_pt.ci   = r_ci;
            o_pt.idx  = 2'd0;
            o_pt.last = 1'b1;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbet_pkg::T_FE_IDLE;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == mbet_pkg::T_FE_IDLE) r_k <= 2'd0;
            else if (r_state == mbet_pkg::T_FE_EMIT && i_pt_ready) r_k <= r_k + 2'd1;
        end
    end

    // coordinate datapath
    always_ff @(posedge i_clk) begin
        if (r_state == mbet_pkg::T_FE_IDLE) begin
            r_dx <= $signed({2'b00, i_px}) - $signed({2'b00, i_width[mbet_pkg::SIZE_W-1:1]});
            r_dy <= $signed({2'b00, i_py}) - $signed({2'b00, i_height[mbet_pkg::SIZE_W-1:1]});
        end
        if (r_state == mbet_pkg::T_FE_MAP) begin
            r_cr <= mbet_pkg::sat_point(w_mx);
            r_ci <= mbet_pkg::sat_point(w_my);
        end
    end
endmodule

/* rtl/mbet_queue.sv */
// two-entry queue of sample points between front and back
// depends on mbet_pkg
module mbet_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mbet_pkg::t_point i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output mbet_pkg::t_point o_data
);
    mbet_pkg::t_point r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end
endmodule

/* rtl/mbet_back.sv */
// back end: iterates z = z*z + c for one sample point at a time
// depends on mbet_pkg
module mbet_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  mbet_pkg::t_point                 i_pt,
    input  logic [mbet_pkg::CNT_W-1:0]       i_limit,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [mbet_pkg::CNT_W-1:0]       o_count,
    output logic signed [mbet_pkg::Z_W-1:0]  o_zr,
    output logic signed [mbet_pkg::Z_W-1:0]  o_zi,
    output logic                             o_escaped,
    output logic [1:0]                       o_idx,
    output logic                             o_last
);
    mbet_pkg::t_be_state r_state, n_state;
    mbet_pkg::t_point    r_pt;
    logic signed [mbet_pkg::Z_W-1:0]    r_zr, r_zi;
    logic [mbet_pkg::CNT_W-1:0]         r_cnt;
    logic                               r_esc;
    logic signed [mbet_pkg::CAP_W-1:0]  r_sr, r_si, r_pm;
    logic signed [mbet_pkg::CAP_W+1:0]  w_re, w_im, w_mag;
    logic signed [mbet_pkg::CAP_W+1:0]  w_four;

    assign w_four = (mbet_pkg::CAP_W+2)'(64'sd4 <<< mbet_pkg::FRAC_BITS);
    assign w_re  = 64'(r_sr) - 64'(r_si) + 64'(r_pt.cr);
    assign w_im  = 64'(r_pm) + 64'(r_pt.ci);
    assign w_mag = 64'(r_sr) + 64'(r_si);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mbet_pkg::T_BE_IDLE: begin
                if (i_valid) n_state = (i_limit == '0) ? mbet_pkg::T_BE_OUT : mbet_pkg::T_BE_UPD;
            end
            mbet_pkg::T_BE_UPD: n_state = mbet_pkg::T_BE_MUL;
            mbet_pkg::T_BE_MUL: n_state = mbet_pkg::T_BE_CHK;
            mbet_pkg::T_BE_CHK: begin
                if (w_mag > w_four || r_cnt + 16'd1 == i_limit) n_state = mbet_pkg::T_BE_OUT;
                else n_state = mbet_pkg::T_BE_UPD;
            end
            mbet_pkg::T_BE_OUT: if (i_ready) n_state = mbet_pkg::T_BE_IDLE;
            default: n_state = mbet_pkg::T_BE_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready   = (r_state == mbet_pkg::T_BE_IDLE);
        o_valid   = (r_state == mbet_pkg::T_BE_OUT);
        o_count   = r_cnt;
        o_zr      = r_zr;
        o_zi      = r_zi;
        o_escaped = r_esc;
        o_idx     = r_pt.idx;
        o_last    = r_pt.last;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mbet_pkg::T_BE_IDLE;
        else r_state <= n_state;
    end

    // iteration datapath: UPD applies the update, MUL forms the products of the new z
    always_ff @(posedge i_clk) begin
        case (r_state)
            mbet_pkg::T_BE_IDLE: begin
                r_pt  <= i_pt;
                r_zr  <= '0;
                r_zi  <= '0;
                r_cnt <= '0;
                r_esc <= 1'b0;
                r_sr  <= '0;
                r_si  <= '0;
                r_pm  <= '0;
            end
            mbet_pkg::T_BE_UPD: begin
                r_zr <= mbet_pkg::sat_z(w_re);
                r_zi <= mbet_pkg::sat_z(w_im);
            end
            mbet_pkg::T_BE_MUL: begin
                r_sr <= mbet_pkg::scale_prod(68'(r_zr) * 68'(r_zr), 1'b0);
                r_si <= mbet_pkg::scale_prod(68'(r_zi) * 68'(r_zi), 1'b0);
                r_pm <= mbet_pkg::scale_prod(68'(r_zr) * 68'(r_zi), 1'b1);
            end
            mbet_pkg::T_BE_CHK: begin
                if (w_mag > w_four) r_esc <= 1'b1;
                else r_cnt <= r_cnt + 16'd1;
            end
            default: ;
        endcase
    end
endmodule

/* rtl/mandelbrot_escape_time_pixel.sv */
// top level of the escape-time pixel engine: config registers, front, queue, back
// depends on mbet_pkg, mbet_front, mbet_queue, mbet_back
// Each pixel becomes one sample point, or four with supersampling on. In the back
// end a point runs through IDLE, then n z updates (n up to iteration_limit, none
// with a zero limit), then OUT, where its result waits for m_axis_tready; each
// update passes through UPD (z update), MUL (products) and CHK (escape test). The
// rate is set by the back end, which works one point at a time. The front maps
// the next pixel while the back iterates.
module mandelbrot_escape_time_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // pixel_x, pixel_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // iteration_count, final_real, final_imag, escaped, sample_index
    output logic        m_axis_tlast
);
    logic signed [31:0] r_scale_x, r_scale_y, r_offset_x, r_offset_y;
    logic [12:0] r_width, r_height;
    logic [15:0] r_limit;
    logic        r_ssmode;
    logic             w_f_valid, w_f_ready, w_q_valid, w_q_ready;
    mbet_pkg::t_point w_f_pt, w_q_pt;
    logic [15:0]        w_cnt;
    logic signed [33:0] w_zr, w_zi;
    logic               w_esc;
    logic [1:0]         w_idx;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x  <= 32'sd1048576;
            r_scale_y  <= 32'sd1048576;
            r_offset_x <= '0;
            r_offset_y <= '0;
            r_width    <= 13'd640;
            r_height   <= 13'd480;
            r_limit    <= 16'd256;
            r_ssmode   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mbet_pkg::REG_SCALE_X:  r_scale_x  <= i_cfg_data;
                mbet_pkg::REG_SCALE_Y:  r_scale_y  <= i_cfg_data;
                mbet_pkg::REG_OFFSET_X: r_offset_x <= i_cfg_data;
                mbet_pkg::REG_OFFSET_Y: r_offset_y <= i_cfg_data;
                mbet_pkg::REG_WIDTH:    r_width    <= i_cfg_data[12:0];
                mbet_pkg::REG_HEIGHT:   r_height   <= i_cfg_data[12:0];
                mbet_pkg::REG_LIMIT:    r_limit    <= i_cfg_data[15:0];
                mbet_pkg::REG_SSMODE:   r_ssmode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mbet_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_px(s_axis_tdata[11:0]), .i_py(s_axis_tdata[23:12]),
        .i_scale_x(r_scale_x), .i_scale_y(r_scale_y),
        .i_offset_x(r_offset_x), .i_offset_y(r_offset_y),
        .i_width(r_width), .i_height(r_height), .i_ssmode(r_ssmode),
        .o_pt_valid(w_f_valid), .i_pt_ready(w_f_ready), .o_pt(w_f_pt)
    );

    mbet_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_f_valid), .o_ready(w_f_ready), .i_data(w_f_pt),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_data(w_q_pt)
    );

    mbet_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_pt(w_q_pt), .i_limit(r_limit),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_count(w_cnt), .o_zr(w_zr), .o_zi(w_zi), .o_escaped(w_esc),
        .o_idx(w_idx), .o_last(m_axis_tlast)
    );

    // result packing, low field first
    assign m_axis_tdata = {1'b0, w_idx, w_esc, w_zi, w_zr, w_cnt};
endmodule

/* rtl/mbet_checker.sv */
// port-level checker for the escape-time pixel engine, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module mbet_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    `CHK_IMPL(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid, "result dropped")
    `CHK_IMPL(a_last3, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[86:85] == 2'd3, m_axis_tlast, "sample 3 not last")
    `CHK_IMPL(a_esc, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[84], m_axis_tdata[15:0] != 16'd0 || (m_axis_tdata[49:16] == '0 && m_axis_tdata[83:50] == '0), "zero count with nonzero z")
    `CHK_ALWAYS(a_pad, i_clk, i_rst_n, m_axis_tdata[87] == 1'b0, "pad bit set")
endmodule

bind mandelbrot_escape_time_pixel mbet_checker u_mbet_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
